[rtl/lbcs_pkg.sv]
package lbcs_pkg;

  localparam int NUM_SEGMENTS = 10;
  localparam int IDX_W        = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 8;
  localparam int VALUE_W = 8;
  localparam int COLOR_W = 3;
  localparam int ANODE_W = 10;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [ADDR_W-1:0] CMD_FILL       = 8'h10;
  localparam logic [ADDR_W-1:0] CMD_SHIFT_UP   = 8'h11;
  localparam logic [ADDR_W-1:0] CMD_SHIFT_DOWN = 8'h12;

  localparam logic [ADDR_W-1:0] NUM_ADDR = ADDR_W'(NUM_SEGMENTS);

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_DRIVE = 1'b1;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic               wr_one;
    logic               fill;
    logic               shift_up;
    logic               shift_down;
    logic               tick;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
  } cell_ctrl_t;

endpackage

[rtl/lbcs_in_if.sv]
interface lbcs_in_if
  import lbcs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [ADDR_W-1:0]  register_address;
  logic [VALUE_W-1:0] write_value;

  modport source (output valid, operation, register_address, write_value, input ready);
  modport sink   (input valid, operation, register_address, write_value, output ready);
endinterface

[rtl/lbcs_out_if.sv]
interface lbcs_out_if
  import lbcs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [COLOR_W-1:0] read_value;
  logic [ANODE_W-1:0] anode_lines;
  logic [COLOR_W-1:0] color_lines_n;

  modport source (output valid, result_kind, read_value, anode_lines, color_lines_n,
                  input ready);
  modport sink   (input valid, result_kind, read_value, anode_lines, color_lines_n,
                  output ready);
endinterface

[rtl/led_bar_color_register_scanner.sv]
// A result enters the output register in the cycle after its item transfers.
// Throughput: one item per cycle; every command is a parallel move in the cell chain.
// Writes, fills, shifts and invalid reads give no result; any item, these too, waits
// while a result sits in the output register and the receiver holds off.
// Reset (asynchronous, active low) clears every segment color to zero and
// places the scan token on segment 0; the output register starts empty.
module led_bar_color_register_scanner
  import lbcs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  lbcs_in_if.sink        in_i,
  lbcs_out_if.source     out_o
);

  // Cell chain wiring: colors run both ways for the shifts, token runs upward.
  logic [COLOR_W-1:0]      color_w [NUM_SEGMENTS];
  logic [COLOR_W-1:0]      read_w  [NUM_SEGMENTS];
  logic [COLOR_W-1:0]      drive_w [NUM_SEGMENTS];
  logic [NUM_SEGMENTS-1:0] token_w;

  cell_ctrl_t ctrl;
  logic       in_accept;
  logic       is_write, is_read, is_tick;
  logic       read_ok;

  logic [COLOR_W-1:0] read_or, drive_or;
  logic [ANODE_W-1:0] anode_w;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [COLOR_W-1:0] read_val_q, read_val_d;
  logic [ANODE_W-1:0] anode_q, anode_d;
  logic [COLOR_W-1:0] color_n_q, color_n_d;

  // Accept whenever the output slot is empty or drains this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  assign is_write = in_accept && (in_i.operation == OP_WRITE);
  assign is_read  = in_accept && (in_i.operation == OP_READ);
  assign is_tick  = in_accept && (in_i.operation == OP_TICK);
  assign read_ok  = in_i.register_address < NUM_ADDR;

  // Decode the write or tick command once and broadcast it down the chain.
  always_comb begin
    ctrl.wr_one     = is_write && read_ok;
    ctrl.fill       = is_write && (in_i.register_address == CMD_FILL);
    ctrl.shift_up   = is_write && (in_i.register_address == CMD_SHIFT_UP);
    ctrl.shift_down = is_write && (in_i.register_address == CMD_SHIFT_DOWN);
    ctrl.tick       = is_tick;
    ctrl.addr       = in_i.register_address;
    ctrl.color      = in_i.write_value[COLOR_W-1:0];
  end

  for (genvar i = 0; i < NUM_SEGMENTS; i++) begin : g_cell
    logic [COLOR_W-1:0] lower, upper;
    logic               tok_in;

    // End cells take the inserted color at the open end of a shift.
    if (i == 0) begin : g_lo_end
      assign lower  = ctrl.color;
      assign tok_in = token_w[NUM_SEGMENTS-1];
    end else begin : g_lo_mid
      assign lower  = color_w[i-1];
      assign tok_in = token_w[i-1];
    end
    if (i == NUM_SEGMENTS-1) begin : g_hi_end
      assign upper = ctrl.color;
    end else begin : g_hi_mid
      assign upper = color_w[i+1];
    end

    lbcs_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .idx_i          (IDX_W'(i)),
      .lower_color_i  (lower),
      .upper_color_i  (upper),
      .token_i        (tok_in),
      .token_invert_i ((i == 0) ? 1'b1 : 1'b0),
      .color_o        (color_w[i]),
      .token_o        (token_w[i]),
      .read_o         (read_w[i]),
      .drive_o        (drive_w[i])
    );
  end

  // Each cell gates its own color, so a plain OR collects the selected one.
  always_comb begin
    read_or  = '0;
    drive_or = '0;
    for (int i = 0; i < NUM_SEGMENTS; i++) begin
      read_or  = read_or  | read_w[i];
      drive_or = drive_or | drive_w[i];
    end
  end

  // Segments past the anode field drive no anode line.
  for (genvar j = 0; j < ANODE_W; j++) begin : g_anode
    if (j < NUM_SEGMENTS) begin : g_on
      assign anode_w[j] = token_w[j];
    end else begin : g_off
      assign anode_w[j] = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    read_val_d  = read_val_q;
    anode_d     = anode_q;
    color_n_d   = color_n_q;
    if (is_read && read_ok) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_READ;
      read_val_d  = read_or;
      anode_d     = '0;
      color_n_d   = '0;
    end else if (is_tick) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_DRIVE;
      read_val_d  = '0;
      anode_d     = anode_w;
      color_n_d   = ~drive_or;
    end else if (in_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload holds while a result waits.
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    read_val_q <= read_val_d;
    anode_q    <= anode_d;
    color_n_q  <= color_n_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = kind_q;
  assign out_o.read_value    = read_val_q;
  assign out_o.anode_lines   = anode_q;
  assign out_o.color_lines_n = color_n_q;

  // Exactly one cell owns the scan token at all times.
  a_token_onehot: assert property (@(posedge clk_i) $onehot(token_w))
    else $error("scan token not one-hot");

  // A tick moves the token one cell up, wrapping after the last segment.
  a_token_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick |=> token_w == (($past(token_w) << 1) | ($past(token_w) >> (NUM_SEGMENTS-1))))
    else $error("scan token did not advance by one segment");

  // An item that yields no result leaves the output slot empty.
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !is_tick && !(is_read && read_ok)) |=> !out_valid_q)
    else $error("result appeared for a write or invalid read");

  // A drive update lights at most one anode line.
  a_drive_anode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == KIND_DRIVE)) |-> $onehot0(anode_q))
    else $error("drive update with several anodes");

endmodule

[rtl/lbcs_cell.sv]
module lbcs_cell
  import lbcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic [COLOR_W-1:0] lower_color_i,
  input  logic [COLOR_W-1:0] upper_color_i,
  input  logic               token_i,
  input  logic               token_invert_i,
  output logic [COLOR_W-1:0] color_o,
  output logic               token_o,
  output logic [COLOR_W-1:0] read_o,
  output logic [COLOR_W-1:0] drive_o
);

  logic [COLOR_W-1:0] color_q, color_d;
  logic               tok_q, tok_d;
  logic               addr_hit;

  assign addr_hit = (ctrl_i.addr == ADDR_W'(idx_i));

  always_comb begin
    color_d = color_q;
    if (ctrl_i.wr_one && addr_hit) begin
      color_d = ctrl_i.color;
    end else if (ctrl_i.fill) begin
      color_d = ctrl_i.color;
    end else if (ctrl_i.shift_up) begin
      color_d = lower_color_i;
    end else if (ctrl_i.shift_down) begin
      color_d = upper_color_i;
    end
  end

  // Stored bit is inverted in the cell that holds the token after reset.
  assign tok_d = ctrl_i.tick ? (token_i ^ token_invert_i) : tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
      tok_q   <= 1'b0;
    end else begin
      color_q <= color_d;
      tok_q   <= tok_d;
    end
  end

  assign color_o = color_q;
  assign token_o = tok_q ^ token_invert_i;
  assign read_o  = addr_hit ? color_q : '0;
  assign drive_o = token_o ? color_q : '0;

endmodule
